// ===== hdl/clnw_pkg.sv =====
`default_nettype none

package clnw_pkg;

  localparam int COLUMNS = 16;
  localparam int COL_W   = $clog2(COLUMNS + 2);

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] LINE2_ADDR   = 8'h40;

  localparam logic [3:0] INIT_LEN  = 4'd14;
  localparam logic [3:0] LINE2_LEN = 4'd2;

  // What precedes the character nibbles of one item.
  localparam logic [1:0] PFX_NONE  = 2'd0;
  localparam logic [1:0] PFX_LINE2 = 2'd1;
  localparam logic [1:0] PFX_INIT  = 2'd2;

  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_INIT = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic       reg_select;
    logic [3:0] nibble;
    logic       last;
  } out_item_t;

  // Decoded work for one item, handed from the decoder to the emitter.
  typedef struct packed {
    logic [1:0] prefix;
    logic       send_char;
    logic [7:0] char_code;
  } plan_t;

  function automatic logic [3:0] init_nibble(input logic [3:0] idx);
    logic [3:0] n;
    case (idx)
      4'd0:    n = 4'd3;
      4'd1:    n = 4'd3;
      4'd2:    n = 4'd3;
      4'd3:    n = 4'd2;
      4'd4:    n = 4'd2;
      4'd5:    n = 4'd8;
      4'd6:    n = 4'd0;
      4'd7:    n = 4'd14;
      4'd8:    n = 4'd0;
      4'd9:    n = 4'd1;
      4'd10:   n = 4'd0;
      4'd11:   n = 4'd6;
      4'd12:   n = 4'd0;
      4'd13:   n = 4'd15;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/clnw_decode.sv =====
`default_nettype none

module clnw_decode (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire clnw_pkg::in_item_t in_data,
  output clnw_pkg::plan_t       plan,
  output logic                  plan_valid,
  input  wire logic             plan_take
);
  import clnw_pkg::*;

  logic [COL_W-1:0] col_r, col_nxt;
  logic             line2_r, line2_nxt;
  plan_t            plan_r, plan_nxt;
  logic             plan_valid_r;
  logic             accept;
  logic [COL_W-1:0] col_inc;
  logic             is_nl;
  logic             wrap;

  assign in_ready   = !plan_valid_r || plan_take;
  assign accept     = in_valid && in_ready;
  assign plan       = plan_r;
  assign plan_valid = plan_valid_r;

  always_comb begin
    is_nl   = (in_data.char_code == NEWLINE_CODE);
    col_inc = (col_r < COL_W'(COLUMNS + 1)) ? col_r + COL_W'(1) : col_r;
    wrap    = (col_inc >= COL_W'(COLUMNS + 1)) || is_nl;

    plan_nxt.char_code = in_data.char_code;
    plan_nxt.prefix    = PFX_NONE;
    plan_nxt.send_char = 1'b0;
    col_nxt            = col_inc;
    line2_nxt          = line2_r;

    if (in_data.req_type == REQ_INIT) begin
      plan_nxt.prefix = PFX_INIT;
      col_nxt         = '0;
      line2_nxt       = 1'b0;
    end else begin
      if (wrap) begin
        col_nxt = '0;
        if (!line2_r) begin
          plan_nxt.prefix = PFX_LINE2;
          line2_nxt       = 1'b1;
        end else begin
          plan_nxt.prefix = PFX_INIT;
          line2_nxt       = 1'b0;
        end
      end
      if (!is_nl) begin
        plan_nxt.send_char = 1'b1;
        if (wrap) begin
          col_nxt = COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      line2_r      <= 1'b0;
      plan_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r        <= col_nxt;
        line2_r      <= line2_nxt;
        plan_valid_r <= 1'b1;
      end else if (plan_take) begin
        plan_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      plan_r <= plan_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/clnw_emit.sv =====
`default_nettype none

module clnw_emit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire clnw_pkg::plan_t    plan,
  input  wire logic               plan_valid,
  output logic                    plan_take,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output clnw_pkg::out_item_t     out_data
);
  import clnw_pkg::*;

  logic [3:0] idx_r;
  logic       out_valid_r;
  out_item_t  out_r, out_nxt;
  logic [3:0] pfx_len;
  logic [3:0] char_idx;
  logic [4:0] total;
  logic       advance;
  logic       is_last;

  always_comb begin
    case (plan.prefix)
      PFX_INIT:  pfx_len = INIT_LEN;
      PFX_LINE2: pfx_len = LINE2_LEN;
      default:   pfx_len = 4'd0;
    endcase
    total    = {1'b0, pfx_len} + (plan.send_char ? 5'd2 : 5'd0);
    is_last  = ({1'b0, idx_r} == total - 5'd1);
    char_idx = idx_r - pfx_len;

    out_nxt.last = is_last;
    if (idx_r < pfx_len) begin
      out_nxt.reg_select = 1'b0;
      if (plan.prefix == PFX_INIT) begin
        out_nxt.nibble = init_nibble(idx_r);
      end else if (idx_r == 4'd0) begin
        // Set DDRAM address command, upper nibble carries the command bit.
        out_nxt.nibble = 4'h8 | {1'b0, LINE2_ADDR[6:4]};
      end else begin
        out_nxt.nibble = LINE2_ADDR[3:0];
      end
    end else begin
      out_nxt.reg_select = 1'b1;
      out_nxt.nibble     = (char_idx == 4'd0) ? plan.char_code[7:4] : plan.char_code[3:0];
    end
  end

  assign advance   = plan_valid && (!out_valid_r || out_ready);
  assign plan_take = advance && is_last;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        idx_r       <= is_last ? 4'd0 : idx_r + 4'd1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/char_lcd_nibble_writer_core.sv =====
// Character LCD nibble writer for a two-line display on a 4-bit bus.
// Input channel (in_valid/in_ready/in_data): one beat is either a request
// to run the start-up sequence or one character byte (newline is code 10).
// Output channel (out_valid/out_ready/out_data): one beat per nibble to put
// on DB7..DB4 with its RS level; last marks the final nibble of an item.
// An item yields between 2 and 16 output beats: two data nibbles for a
// character, plus two command nibbles on a wrap from line one or the
// 14-nibble start-up sequence on a wrap from line two or an init request.
// An accepted input beat passes the plan register, then the output register,
// before its first output beat. Output beats leave at one per cycle while the
// receiver is ready; the emitter walks the nibble list of the item held in
// the plan register. The next item is decoded into that plan register in the
// same cycle as the last nibble of the current one enters the output register.
// A stalled receiver holds the output register, which in turn holds the
// plan register, and in_ready drops once both are full.
// Reset clears the column counter, selects line one and empties both
// stages; no start-up sequence is sent until one is requested.
`default_nettype none

module char_lcd_nibble_writer_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire clnw_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output clnw_pkg::out_item_t      out_data
);
  import clnw_pkg::*;

  plan_t plan;
  logic  plan_valid;
  logic  plan_take;

  // Tracks the cursor line and column and turns each beat into a plan.
  clnw_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .plan       (plan),
    .plan_valid (plan_valid),
    .plan_take  (plan_take)
  );

  // Steps through the plan into the output register, one nibble per cycle while the output is not stalled.
  clnw_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .plan       (plan),
    .plan_valid (plan_valid),
    .plan_take  (plan_take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

// ===== hdl/clnw_checker.sv =====
`default_nettype none

module clnw_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire clnw_pkg::in_item_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire clnw_pkg::out_item_t out_data
);

  // A waiting input beat holds until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input beat changed while waiting");

  // A stalled output beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // Reset empties the output stage.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Nibbles of one item leave without gaps.
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last |=> out_valid)
    else $error("gap inside an item");

  // A high data nibble is always followed by the closing low data nibble.
  a_char_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.reg_select && !out_data.last
    |=> out_valid && out_data.reg_select && out_data.last)
    else $error("data nibble pair broken");

endmodule

bind char_lcd_nibble_writer_core clnw_checker u_clnw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== verif/lcd_bus_checker.sv =====
// Watches both channels of the nibble writer, predicts the bus nibbles of
// every accepted input beat and compares them with the output beats in order.
module lcd_bus_checker (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire clnw_pkg::in_item_t  in_data,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire clnw_pkg::out_item_t out_data,
  output int                       fail_count,
  output int                       nibbles_due
);
  import clnw_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // Start-up sequence, first nibble in the top four bits.
  localparam logic [55:0] START_SEQ = {4'd3, 4'd3, 4'd3, 4'd2, 4'd2, 4'd8, 4'd0,
                                       4'd14, 4'd0, 4'd1, 4'd0, 4'd6, 4'd0, 4'd15};

  logic [COL_W-1:0] col_count;
  logic             line_two;
  out_item_t        bus_nibble_q[$];
  out_item_t        want;
  int               errors;
  int               beat_index;

  initial begin
    col_count  = '0;
    line_two   = 1'b0;
    errors     = 0;
    beat_index = 0;
  end

  function automatic void push_nibble(input logic rs, input logic [3:0] nib);
    out_item_t entry;
    entry.reg_select = rs;
    entry.nibble     = nib;
    entry.last       = 1'b0;
    bus_nibble_q.push_back(entry);
  endfunction

  function automatic void push_start_seq();
    for (int i = 0; i < 14; i++) begin
      push_nibble(1'b0, START_SEQ[55 - 4 * i -: 4]);
    end
    col_count = '0;
    line_two  = 1'b0;
  endfunction

  function automatic void predict_bus_nibbles(input in_item_t beat);
    logic is_newline;
    logic wrapped;
    is_newline = (beat.char_code == NEWLINE_CODE);
    wrapped    = 1'b0;
    if (beat.req_type == REQ_INIT) begin
      push_start_seq();
    end else begin
      if (col_count < COLUMNS + 1) begin
        col_count = col_count + 1'b1;
      end
      if (col_count >= COLUMNS + 1 || is_newline) begin
        wrapped = 1'b1;
        if (!line_two) begin
          // Set DDRAM address 0x40: command bit plus the address high bits.
          push_nibble(1'b0, 4'h8 | {1'b0, LINE2_ADDR[6:4]});
          push_nibble(1'b0, LINE2_ADDR[3:0]);
          line_two  = 1'b1;
          col_count = '0;
        end else begin
          push_start_seq();
        end
      end
      if (!is_newline) begin
        push_nibble(1'b1, beat.char_code[7:4]);
        push_nibble(1'b1, beat.char_code[3:0]);
        if (wrapped) begin
          col_count = COL_W'(1);
        end
      end
    end
    bus_nibble_q[bus_nibble_q.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      col_count = '0;
      line_two  = 1'b0;
      bus_nibble_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        predict_bus_nibbles(in_data);
      end
      if (out_valid && out_ready) begin
        if (bus_nibble_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("beat %0d: unexpected nibble rs=%0b nib=%h last=%0b",
                     beat_index, out_data.reg_select, out_data.nibble, out_data.last);
          end
        end else begin
          want = bus_nibble_q.pop_front();
          if (out_data.reg_select !== want.reg_select || out_data.nibble !== want.nibble ||
              out_data.last !== want.last) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
              $display("beat %0d: expected rs=%0b nib=%h last=%0b, got rs=%0b nib=%h last=%0b",
                       beat_index, want.reg_select, want.nibble, want.last,
                       out_data.reg_select, out_data.nibble, out_data.last);
            end
          end
        end
        beat_index++;
      end
    end
    fail_count  <= errors;
    nibbles_due <= bus_nibble_q.size();
  end

endmodule

// ===== verif/char_lcd_nibble_writer_core_tb.sv =====
// Stimulus and verdict for the nibble writer. The checker beside the block
// does all prediction and comparison; this module only drives beats, shapes
// the idle patterns and decides the outcome from the checker's counts.
module char_lcd_nibble_writer_core_tb;
  import clnw_pkg::*;

  // Far above the slowest legal run: a few hundred items, each at most 16
  // nibbles, with the receiver idling three quarters of the time plus one long hold.
  localparam int RUN_LIMIT   = 500000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 20;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_data;

  int fail_count;
  int nibbles_due;

  // Idle percentages. The receiver's is read by its own process, so it is
  // only ever updated with nonblocking assignments.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // A hold request is a bump of this counter; the receiver process notices
  // the difference and counts the stall out on its own.
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;

  int cycle_count = 0;

  always #2 clk = ~clk;

  char_lcd_nibble_writer_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  lcd_bus_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .nibbles_due (nibbles_due)
  );

  // Receiver: random backpressure, or a long solid stall set by HOLD_CYCLES when the
  // stimulus asks for one. During the stall the block's two stages fill and
  // in_ready must drop while the sender keeps offering beats.
  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served <= hold_requests;
      hold_left    <= HOLD_CYCLES;
      out_ready    <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("char_lcd_nibble_writer_core verification failed");
      $finish;
    end
  end

  // Offers one beat and returns at the edge where it is taken. Idle cycles
  // before it put junk on in_data with valid low, which the block must ignore.
  task automatic send_item(input in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= {1'($urandom), 8'($urandom)};
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drops valid and waits for the checker to report no nibbles outstanding.
  // The first edge is always taken, since the count is registered behind the handshake.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (nibbles_due != 0);
  endtask

  // Characters of one display line, optionally closed by a newline. Lengths of
  // seventeen or more run into the full-line wrap with a character.
  task automatic send_line(input int len, input bit with_newline);
    for (int i = 0; i < len; i++) begin
      send_item({REQ_CHAR, 8'($urandom)});
    end
    if (with_newline) begin
      send_item({REQ_CHAR, NEWLINE_CODE});
    end
  endtask

  // Mostly well-formed text: lines of random content, some long enough to
  // wrap by themselves, usually ended by a newline so that both line-one and
  // line-two wraps keep happening. Init requests and stray bytes mix in.
  task automatic send_random_text(input int count);
    int sent;
    int pick;
    int len;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_item({REQ_INIT, 8'($urandom)});
        sent += 1;
      end else if (pick < 14) begin
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) begin
          send_item({1'($urandom), 8'($urandom)});
        end
        sent += len;
      end else begin
        len = $urandom_range(1) ? $urandom_range(16, 20) : $urandom_range(0, 15);
        send_line(len, $urandom_range(3) != 0);
        sent += len + 1;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: init with both extreme char codes, a newline wrap
    // from each line, and a full line whose seventeenth character wraps and
    // lands in column one.
    send_item({REQ_INIT, 8'h00});
    send_item({REQ_CHAR, NEWLINE_CODE});
    send_item({REQ_CHAR, NEWLINE_CODE});
    send_item({REQ_CHAR, 8'h00});
    send_item({REQ_CHAR, 8'hFF});
    for (int i = 0; i < 14; i++) begin
      send_item({REQ_CHAR, 8'h30 + 8'(i)});
    end
    send_item({REQ_CHAR, 8'hA5});
    send_item({REQ_CHAR, 8'h5A});
    send_item({REQ_INIT, 8'hFF});

    // Phase one: rarely idle sender, heavily stalled receiver.
    send_idle_pct = 14;
    recv_idle_pct <= 74;
    send_random_text(95);

    // Phase two: the other way round.
    send_idle_pct = 74;
    recv_idle_pct <= 14;
    send_random_text(95);

    // Phase three: no idling at all. It opens with a long receiver hold
    // while beats keep coming, then a full drain before the rest.
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_requests <= hold_requests + 1;
    send_random_text(30);
    wait_for_drain();
    send_random_text(90);

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && nibbles_due == 0) begin
      $display("char_lcd_nibble_writer_core verification clean");
    end else begin
      $display("char_lcd_nibble_writer_core verification failed");
    end
    $finish;
  end

endmodule
